[hw/rtl/modular_exponentiation_top_defines.svh]
// Assertion macros shared by the modular exponentiation RTL.
// Depends on a clock named clk_i and an active-low reset named rst_ni in the including scope.
`ifndef MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

`ifndef SYNTH
`define MX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MX_ASSERT(lbl, prop, msg)
`define MX_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hw/rtl/modexp_pkg.sv]
// Package for the modular exponentiation block: widths, register indexes, types.
// Used by every module of the block; depends on nothing.
package modexp_pkg;

  localparam int MOD_WIDTH_DEF   = 31;
  localparam int BASE_WIDTH      = 32;
  localparam int CFG_INDEX_WIDTH = 1;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODULUS  = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPONENT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_OUT
  } modexp_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } modexp_status_t;

endpackage

[hw/rtl/modular_exponentiation_top.sv]
// Top level of the modular exponentiation block: configuration registers, sequencer, output register.
// Depends on modexp_pkg, modexp_div, modexp_mul and the assertion macro header.
//
// Each input transaction yields power_result = base_value ^ exponent mod modulus, one
// transaction at a time. The block first reduces the input modulo the modulus
// (one dividend bit per cycle), then walks the exponent from its lowest bit up to its
// highest set bit. Every exponent bit costs a decision step in ST_STEP plus a squaring,
// and a set bit adds a multiplication before the squaring; both run on the one shared
// bit-serial modular multiplier, which sets the rate. A zero exponent or a zero modulus
// skips the reduction and goes straight to the output state. The next input
// transaction is taken once the result sits in the output register.
`include "modular_exponentiation_top_defines.svh"

module modular_exponentiation_top #(
  parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [MOD_WIDTH-1:0]                   cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [modexp_pkg::BASE_WIDTH-1:0]      base_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [MOD_WIDTH-1:0]                   power_result_o
);
  import modexp_pkg::*;

  modexp_state_e        state_q, state_d;
  logic [MOD_WIDTH-1:0] modulus_q, exponent_q;
  logic [MOD_WIDTH-1:0] res_q, res_d;
  logic [MOD_WIDTH-1:0] b_q, b_d;
  logic [MOD_WIDTH-1:0] eshift_q, eshift_d;
  logic [MOD_WIDTH-1:0] out_data_q, out_data_d;
  logic                 out_valid_q, out_valid_d;
  logic                 div_start, mul_start, mul_square, load_out, in_stall;
  logic [MOD_WIDTH-1:0] div_rem, mul_prod, mul_a;
  modexp_status_t       div_status, mul_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= MOD_WIDTH'(1);
      exponent_q <= '0;
    end else if (cfg_we_i) begin
      priority if (cfg_index_i == CFG_MODULUS) begin
        modulus_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_EXPONENT) begin
        exponent_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (exponent_q == '0 || modulus_q == '0) ? ST_OUT : ST_REDUCE;
        end
      end
      ST_REDUCE: if (div_status.done) state_d = ST_STEP;
      ST_STEP: begin
        if (eshift_q == '0) begin
          state_d = ST_OUT;
        end else if (eshift_q[0]) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_SQR;
        end
      end
      ST_MUL: if (mul_status.done) state_d = ST_SQR;
      ST_SQR: if (mul_status.done) state_d = ST_STEP;
      ST_OUT: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_d      = res_q;
    b_d        = b_q;
    eshift_d   = eshift_q;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    mul_square = 1'b0;
    load_out   = 1'b0;
    in_stall   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid_i) begin
          eshift_d = exponent_q;
          if (exponent_q == '0) begin
            res_d = MOD_WIDTH'(1);
          end else if (modulus_q == '0) begin
            res_d = '0;
          end else begin
            div_start = 1'b1;
            res_d     = (modulus_q == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
          end
        end
      end
      ST_REDUCE: if (div_status.done) b_d = div_rem;
      ST_STEP: begin
        if (eshift_q != '0) begin
          mul_start  = 1'b1;
          mul_square = !eshift_q[0];
        end
      end
      ST_MUL: begin
        if (mul_status.done) begin
          res_d      = mul_prod;
          mul_start  = 1'b1;
          mul_square = 1'b1;
        end
      end
      ST_SQR: begin
        if (mul_status.done) begin
          b_d      = mul_prod;
          eshift_d = eshift_q >> 1;
        end
      end
      ST_OUT: load_out = !out_valid_q || !out_stall_i;
      default: in_stall = 1'b1;
    endcase
  end

  assign mul_a       = mul_square ? b_q : res_q;
  assign out_valid_d = load_out || (out_valid_q && out_stall_i);
  assign out_data_d  = load_out ? res_q : out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    b_q        <= b_d;
    eshift_q   <= eshift_d;
    out_data_q <= out_data_d;
  end

  modexp_div #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (base_value_i),
    .modulus_i  (modulus_q),
    .status_o   (div_status),
    .rem_o      (div_rem)
  );

  modexp_mul #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (b_q),
    .modulus_i (modulus_q),
    .status_o  (mul_status),
    .prod_o    (mul_prod)
  );

  assign in_stall_o     = in_stall;
  assign out_valid_o    = out_valid_q;
  assign power_result_o = out_data_q;

  `MX_ASSERT(a_div_done, div_status.done |-> state_q == ST_REDUCE, "reduction done off state")
  `MX_ASSERT(a_mul_done, mul_status.done |-> (state_q == ST_MUL || state_q == ST_SQR), "stray done")
  `MX_ASSERT(a_base_reduced, (state_q == ST_STEP) |-> b_q < modulus_q, "base not below modulus")
  `MX_ASSERT(a_res_reduced, (state_q == ST_SQR) |-> res_q < modulus_q, "result not reduced")
  `MX_ASSERT(a_no_overlap, !(div_status.busy && mul_status.busy), "divider and multiplier busy")

endmodule

[hw/rtl/modexp_div.sv]
// Bit-serial restoring reduction of the input block modulo the modulus.
// Depends on modexp_pkg; one dividend bit per cycle.
module modexp_div #(
  parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [modexp_pkg::BASE_WIDTH-1:0]   dividend_i,
  input  logic [MOD_WIDTH-1:0]                modulus_i,
  output modexp_pkg::modexp_status_t          status_o,
  output logic [MOD_WIDTH-1:0]                rem_o
);
  import modexp_pkg::*;

  localparam int CntW = $clog2(BASE_WIDTH + 1);

  logic [BASE_WIDTH-1:0] quo_q, quo_d;
  logic [MOD_WIDTH-1:0]  rem_q, rem_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [MOD_WIDTH:0]    trial, mod_ext, diff;

  assign trial   = {rem_q, quo_q[BASE_WIDTH-1]};
  assign mod_ext = {1'b0, modulus_i};
  assign diff    = trial - mod_ext;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CntW'(BASE_WIDTH);
    end else if (cnt_q != '0) begin
      quo_d  = {quo_q[BASE_WIDTH-2:0], 1'b0};
      rem_d  = (trial >= mod_ext) ? diff[MOD_WIDTH-1:0] : trial[MOD_WIDTH-1:0];
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = done_q;
  assign rem_o         = rem_q;

endmodule

[hw/rtl/modexp_mul.sv]
// Bit-serial interleaved modular multiplier, multiplier operand scanned from the top bit.
// Depends on modexp_pkg; one multiplier bit per cycle, operands below the modulus.
module modexp_mul #(
  parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [MOD_WIDTH-1:0]        a_i,
  input  logic [MOD_WIDTH-1:0]        b_i,
  input  logic [MOD_WIDTH-1:0]        modulus_i,
  output modexp_pkg::modexp_status_t  status_o,
  output logic [MOD_WIDTH-1:0]        prod_o
);
  import modexp_pkg::*;

  localparam int CntW = $clog2(MOD_WIDTH + 1);

  logic [MOD_WIDTH-1:0] a_q, a_d;
  logic [MOD_WIDTH-1:0] b_q, b_d;
  logic [MOD_WIDTH-1:0] acc_q, acc_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [MOD_WIDTH+1:0] sum, once_m, twice_m, sub1, sub2;

  assign once_m  = {2'b00, modulus_i};
  assign twice_m = {1'b0, modulus_i, 1'b0};
  assign sum     = {1'b0, acc_q, 1'b0} + (b_q[MOD_WIDTH-1] ? {2'b00, a_q} : '0);
  assign sub1    = sum - once_m;
  assign sub2    = sum - twice_m;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d   = a_i;
      b_d   = b_i;
      acc_d = '0;
      cnt_d = CntW'(MOD_WIDTH);
    end else if (cnt_q != '0) begin
      b_d    = {b_q[MOD_WIDTH-2:0], 1'b0};
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
      if (sum >= twice_m) begin
        acc_d = sub2[MOD_WIDTH-1:0];
      end else if (sum >= once_m) begin
        acc_d = sub1[MOD_WIDTH-1:0];
      end else begin
        acc_d = sum[MOD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = done_q;
  assign prod_o        = acc_q;

endmodule
